// File: rtl/srtm_pkg.sv
// ----------------------------------------------------------------------------
// srtm_pkg
// Shared types and constants for the send/receive tag match table.
// ----------------------------------------------------------------------------
package srtm_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int RANK_BITS_DEF   = 16;
  localparam int ADDR_BITS_DEF   = 48;

  localparam int BYTES_W  = 32;
  localparam int SEQ_W    = 31;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED = 3'd0,
    ST_PUT    = 3'd1,
    ST_SIZE   = 3'd2,
    ST_DUP    = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE
  } state_t;

  // table port commands; addresses travel beside it
  typedef struct packed {
    logic rd;
    logic store;
    logic clear;
  } tbl_cmd_t;

endpackage

// File: rtl/srtm_table.sv
// ----------------------------------------------------------------------------
// srtm_table
// Entry storage: one synchronous row memory plus a flop valid bit per entry.
// ----------------------------------------------------------------------------
module srtm_table import srtm_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int ROW_W = 8,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  tbl_cmd_t         cmd,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [ROW_W-1:0] wr_row,
  output logic             rd_valid,
  output logic [ROW_W-1:0] rd_row
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[wr_addr] <= wr_row;
    end
    if (cmd.rd) begin
      rd_row <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.store) begin
        valid[wr_addr] <= 1'b1;
      end
      if (cmd.clear) begin
        valid[wr_addr] <= 1'b0;
      end
      if (cmd.rd) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

endmodule

// File: rtl/srtm_ctrl.sv
// ----------------------------------------------------------------------------
// srtm_ctrl
// Scan sequencer: walks the table one entry a cycle, resolves hit or miss,
// updates the table and fills the result register.
// ----------------------------------------------------------------------------
module srtm_ctrl import srtm_pkg::*; #(
  parameter int DEPTH     = TABLE_DEPTH_DEF,
  parameter int RANK_BITS = RANK_BITS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int ROW_W = RANK_BITS + SEQ_W + 2 * ADDR_BITS + BYTES_W + 3 * HANDLE_W
) (
  input  logic                 clk,
  input  logic                 rst,
  // request side
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [RANK_BITS-1:0] dest_rank,
  input  logic [ADDR_BITS-1:0] src_addr,
  input  logic [ADDR_BITS-1:0] dst_addr,
  input  logic [BYTES_W-1:0]   byte_count,
  input  logic [SEQ_W-1:0]     seq_num,
  input  logic [HANDLE_W-1:0]  signal_handle,
  input  logic [HANDLE_W-1:0]  done_handle,
  input  logic [HANDLE_W-1:0]  counter_handle,
  // table port
  output tbl_cmd_t             cmd,
  output logic [IDX_W-1:0]     rd_addr,
  output logic [IDX_W-1:0]     wr_addr,
  output logic [ROW_W-1:0]     wr_row,
  input  logic                 rd_valid,
  input  logic [ROW_W-1:0]     rd_row,
  // result side
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output status_t              status,
  output logic [ADDR_BITS-1:0] put_src,
  output logic [ADDR_BITS-1:0] put_dst,
  output logic [BYTES_W-1:0]   put_bytes,
  output logic [HANDLE_W-1:0]  put_signal,
  output logic [HANDLE_W-1:0]  put_done,
  output logic [HANDLE_W-1:0]  put_counter
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  state_t state, state_next;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] free_idx;
  logic             free_found;
  logic             load_out;
  logic             match;
  logic             last;

  // held request
  logic [RANK_BITS-1:0] req_rank;
  logic [ADDR_BITS-1:0] req_src;
  logic [ADDR_BITS-1:0] req_dst;
  logic [BYTES_W-1:0]   req_bytes;
  logic [SEQ_W-1:0]     req_seq;
  logic [HANDLE_W-1:0]  req_signal;
  logic [HANDLE_W-1:0]  req_done;
  logic [HANDLE_W-1:0]  req_counter;

  // entry under inspection
  logic [RANK_BITS-1:0] e_rank;
  logic [ADDR_BITS-1:0] e_src;
  logic [ADDR_BITS-1:0] e_dst;
  logic [BYTES_W-1:0]   e_bytes;
  logic [SEQ_W-1:0]     e_seq;
  logic [HANDLE_W-1:0]  e_signal;
  logic [HANDLE_W-1:0]  e_done;
  logic [HANDLE_W-1:0]  e_counter;

  status_t              res_status;
  logic [ADDR_BITS-1:0] res_src;
  logic [ADDR_BITS-1:0] res_dst;
  logic [BYTES_W-1:0]   res_bytes;
  logic [HANDLE_W-1:0]  res_signal;
  logic [HANDLE_W-1:0]  res_done;
  logic [HANDLE_W-1:0]  res_counter;

  assign wr_row = {req_counter, req_done, req_signal, req_bytes,
                   req_dst, req_src, req_seq, req_rank};
  assign {e_counter, e_done, e_signal, e_bytes, e_dst, e_src, e_seq, e_rank} = rd_row;

  // read data stays put once the scan stops, so the match holds into resolve
  assign match = rd_valid && (e_rank == req_rank) && (e_seq == req_seq);
  assign last  = (cnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    rd_addr    = cnt + IDX_W'(1);
    s_tready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        rd_addr  = '0;
        if (s_tvalid) begin
          cmd.rd     = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (match || last) begin
          state_next = S_RESOLVE;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      S_RESOLVE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          cmd.clear  = match;
          cmd.store  = !match && free_found;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // on a hit the scan index still points at the matching entry
  assign wr_addr = match ? cnt : free_idx;

  always_comb begin
    res_status  = ST_FULL;
    res_src     = '0;
    res_dst     = '0;
    res_bytes   = '0;
    res_signal  = '0;
    res_done    = '0;
    res_counter = '0;
    if (match) begin
      if (req_bytes != e_bytes) begin
        res_status = ST_SIZE;
      end else if ((e_src == '0) == (req_src == '0)) begin
        res_status = ST_DUP;
      end else begin
        res_status = ST_PUT;
        res_bytes  = e_bytes;
        if (e_src == '0) begin
          res_src     = req_src;
          res_dst     = e_dst;
          res_signal  = e_signal;
          res_done    = req_done;
          res_counter = req_counter;
        end else begin
          res_src     = e_src;
          res_dst     = req_dst;
          res_signal  = req_signal;
          res_done    = e_done;
          res_counter = e_counter;
        end
      end
    end else if (free_found) begin
      res_status = ST_STORED;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      req_rank    <= dest_rank;
      req_src     <= src_addr;
      req_dst     <= dst_addr;
      req_bytes   <= byte_count;
      req_seq     <= seq_num;
      req_signal  <= signal_handle;
      req_done    <= done_handle;
      req_counter <= counter_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      free_idx   <= '0;
      free_found <= 1'b0;
    end else begin
      if (state == S_IDLE) begin
        cnt        <= '0;
        free_found <= 1'b0;
      end else if (state == S_SCAN) begin
        if (!(match || last)) begin
          cnt <= cnt + IDX_W'(1);
        end
        // first empty slot seen is where a miss gets stored
        if (!rd_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cnt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= res_status;
      put_src     <= res_src;
      put_dst     <= res_dst;
      put_bytes   <= res_bytes;
      put_signal  <= res_signal;
      put_done    <= res_done;
      put_counter <= res_counter;
    end
  end

endmodule

// File: rtl/send_recv_tag_match_table.sv
// ----------------------------------------------------------------------------
// send_recv_tag_match_table
// Pairs send and receive halves of point-to-point transfers by rank and
// sequence number and issues one put command per matched pair.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_tvalid/s_tready/s_tdata; a request with src_addr zero
//   is a receive half, any other is a send half. Every request yields exactly
//   one result on m_tvalid/m_tready/m_tdata, with its status in m_tuser.
//   Put fields in m_tdata are zero unless the status is put issued.
// Timing:
//   One request is handled at a time. The table is read one entry per cycle
//   from a synchronous memory with a registered read; the scan stops at the
//   first matching entry or at the last of the TABLE_DEPTH entries (16 by
//   default), and a resolve step then updates the table and loads the result.
// Reset:
//   rst clears all valid bits at once; the table is empty and ready in the
//   first cycle after reset. No clearing pass is needed.
// Backpressure:
//   The result sits in an output register. A new request is accepted while
//   it waits; that request's scan runs, and its table update is held until
//   the output register frees up.
// ----------------------------------------------------------------------------
module send_recv_tag_match_table import srtm_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int RANK_BITS   = RANK_BITS_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF,
  localparam int IN_W       = RANK_BITS + 2 * ADDR_BITS + BYTES_W + SEQ_W + 3 * HANDLE_W,
  localparam int IN_DATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W      = 2 * ADDR_BITS + BYTES_W + 3 * HANDLE_W,
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // dest_rank, src_addr, dst_addr, byte_count, seq_num,
  // signal_handle, done_handle, counter_handle, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // put_src, put_dst, put_bytes, put_signal, put_done, put_counter, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status
  output logic [STATUS_W-1:0]   m_tuser
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int ROW_W = RANK_BITS + SEQ_W + 2 * ADDR_BITS + BYTES_W + 3 * HANDLE_W;

  localparam int O_SRC = RANK_BITS;
  localparam int O_DST = O_SRC + ADDR_BITS;
  localparam int O_BYT = O_DST + ADDR_BITS;
  localparam int O_SEQ = O_BYT + BYTES_W;
  localparam int O_SIG = O_SEQ + SEQ_W;
  localparam int O_DON = O_SIG + HANDLE_W;
  localparam int O_CNT = O_DON + HANDLE_W;

  tbl_cmd_t             cmd;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic [ROW_W-1:0]     wr_row;
  logic                 rd_valid;
  logic [ROW_W-1:0]     rd_row;

  status_t              status;
  logic [ADDR_BITS-1:0] put_src;
  logic [ADDR_BITS-1:0] put_dst;
  logic [BYTES_W-1:0]   put_bytes;
  logic [HANDLE_W-1:0]  put_signal;
  logic [HANDLE_W-1:0]  put_done;
  logic [HANDLE_W-1:0]  put_counter;

  srtm_ctrl #(
    .DEPTH     (TABLE_DEPTH),
    .RANK_BITS (RANK_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .dest_rank      (s_tdata[RANK_BITS-1:0]),
    .src_addr       (s_tdata[O_SRC +: ADDR_BITS]),
    .dst_addr       (s_tdata[O_DST +: ADDR_BITS]),
    .byte_count     (s_tdata[O_BYT +: BYTES_W]),
    .seq_num        (s_tdata[O_SEQ +: SEQ_W]),
    .signal_handle  (s_tdata[O_SIG +: HANDLE_W]),
    .done_handle    (s_tdata[O_DON +: HANDLE_W]),
    .counter_handle (s_tdata[O_CNT +: HANDLE_W]),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr),
    .wr_row         (wr_row),
    .rd_valid       (rd_valid),
    .rd_row         (rd_row),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .status         (status),
    .put_src        (put_src),
    .put_dst        (put_dst),
    .put_bytes      (put_bytes),
    .put_signal     (put_signal),
    .put_done       (put_done),
    .put_counter    (put_counter)
  );

  srtm_table #(
    .DEPTH (TABLE_DEPTH),
    .ROW_W (ROW_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_row   (wr_row),
    .rd_valid (rd_valid),
    .rd_row   (rd_row)
  );

  assign m_tuser = status;
  assign m_tdata = OUT_DATA_W'({put_counter, put_done, put_signal,
                                put_bytes, put_dst, put_src});

  // a table entry is never written and freed in the same cycle
  assert property (@(posedge clk) disable iff (rst) !(cmd.store && cmd.clear))
    else $error("store and clear issued together");

  // table updates only happen while a request is in flight
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(cmd.store || cmd.clear || !s_tvalid && cmd.rd))
    else $error("table access while idle");

  // every table update comes with a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (cmd.store || cmd.clear) |=> m_tvalid)
    else $error("table update without result");

  // put fields are zero unless a put is issued
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status != ST_PUT) |-> (m_tdata == '0))
    else $error("put fields set on non-put result");

endmodule
